@@ rtl/ibmq_pkg.sv @@
`timescale 1ns / 1ps

package ibmq_pkg;

	localparam int unsigned POS_W         = 21;
	localparam int unsigned SEQ_W         = 8;
	localparam int unsigned MAP_POSITIONS = 1048576;
	localparam int unsigned WORD_BITS     = 64;
	localparam int unsigned MAX_SEQS      = 256;
	localparam int unsigned WORD_W        = $clog2(WORD_BITS);
	localparam int unsigned MAP_WORDS     = (MAP_POSITIONS + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned MAP_AW        = $clog2(MAP_WORDS);
	localparam int unsigned GPOS_W        = POS_W + 1;

	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_MARK  = 2'd1;
	localparam logic [1:0] REQ_RANGE = 2'd2;
	localparam logic [1:0] REQ_POINT = 2'd3;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FORM  = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [SEQ_W-1:0] seq_index;
		logic [POS_W-1:0] from_pos;
		logic             from_valid;
		logic [POS_W-1:0] to_pos;
		logic             to_valid;
		logic [POS_W-1:0] offset_value;
	} ibmq_req_t;

	typedef struct packed {
		logic       hit;
		logic [1:0] status;
	} ibmq_rsp_t;

	// result handover from the sequencer to the output register
	typedef struct packed {
		logic      valid;
		ibmq_rsp_t rsp;
	} ibmq_res_t;

endpackage

@@ rtl/interval_bitmap_mark_and_query.sv @@
`timescale 1ns / 1ps

// Coverage bitmap of 1048576 positions (16384 words of 64 bits) with a 256-entry
// sequence offset table. After reset the block sweeps the map to zero, one word a
// cycle, and holds req_stall high until the sweep is done. Items are handled one at
// a time; each gives exactly one response. A load or a malformed request goes
// straight to its result; any other request first reads its offset, and one whose
// interval lies beyond the map ends there. A mark or range query then walks the
// map words the interval touches (one map word read a cycle, marks written back in
// the following cycle; a range query stops at the first word with a hit), and a
// point query reads its one word. The next request is taken only after the
// result has passed to the output register, which holds the response, so a new
// request is taken while the previous response waits.
module interval_bitmap_mark_and_query
	import ibmq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  ibmq_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output ibmq_rsp_t rsp
);

	ibmq_res_t res;
	logic      res_free;
	logic      rsp_valid_q;
	ibmq_rsp_t rsp_q;

	assign res_free = !rsp_valid_q || !rsp_stall;

	ibmq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.busy      (req_stall),
		.req       (req),
		.res       (res),
		.res_free  (res_free)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_free) begin
			rsp_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && res.valid) begin
			rsp_q <= res.rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ rtl/ibmq_ram.sv @@
`timescale 1ns / 1ps

module ibmq_ram #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/ibmq_ctrl.sv @@
`timescale 1ns / 1ps

module ibmq_ctrl
	import ibmq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      busy,
	input  ibmq_req_t req,
	output ibmq_res_t res,
	input  logic      res_free
);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_OFS  = 3'd2;
	localparam logic [2:0] ST_WALK = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam logic [GPOS_W-1:0] MapLimit = GPOS_W'(MAP_POSITIONS);
	localparam logic [WORD_W-1:0] TopBit   = WORD_W'(WORD_BITS - 1);

	logic [2:0]          state_q;
	logic [MAP_AW-1:0]   clr_cnt_q;
	logic [1:0]          type_q;
	logic [POS_W-1:0]    from_q;
	logic [POS_W-1:0]    to_q;
	logic                fv_q;
	logic [MAP_AW-1:0]   first_q;
	logic [MAP_AW-1:0]   last_q;
	logic [WORD_W-1:0]   lo_q;
	logic [WORD_W-1:0]   hi_q;
	logic [MAP_AW-1:0]   rd_addr_q;
	logic                issue_q;
	logic                v_s1;
	logic [MAP_AW-1:0]   addr_s1;
	ibmq_rsp_t           rsp_q;

	logic                acc;
	logic                err_form;
	logic [POS_W-1:0]    ofs_rdata;
	logic [WORD_BITS-1:0] map_rdata;
	logic                map_we;
	logic [MAP_AW-1:0]   map_waddr;
	logic [WORD_BITS-1:0] map_wdata;
	logic                map_re;
	logic [GPOS_W-1:0]   base;
	logic [POS_W-1:0]    pos_sel;
	logic [GPOS_W-1:0]   a_pos;
	logic [GPOS_W-1:0]   b_pos;
	logic [GPOS_W-1:0]   l_pos;
	logic                over;
	logic                is_point;
	logic                is_mark;
	logic [WORD_W-1:0]   lo_w;
	logic [WORD_W-1:0]   hi_w;
	logic [WORD_BITS-1:0] mask;
	logic                word_hit;
	logic                walk_end;
	logic                issue;

	assign busy = (state_q != ST_IDLE);
	assign acc  = req_valid && !busy;

	always_comb begin
		case (req.req_type)
			REQ_MARK, REQ_RANGE: err_form = !req.from_valid || !req.to_valid ||
			                                (req.from_pos >= req.to_pos);
			REQ_POINT:           err_form = !req.from_valid && !req.to_valid;
			default:             err_form = 1'b0;
		endcase
	end

	// offset table: loaded on transfer, read on every accepted request
	ibmq_ram #(
		.DEPTH (MAX_SEQS),
		.WIDTH (POS_W)
	) u_ofs (
		.clk   (clk),
		.we    (acc && req.req_type == REQ_LOAD),
		.waddr (req.seq_index),
		.wdata (req.offset_value),
		.re    (acc),
		.raddr (req.seq_index),
		.rdata (ofs_rdata)
	);

	// global interval from the loaded offset
	assign is_point = (type_q == REQ_POINT);
	assign is_mark  = (type_q == REQ_MARK);
	assign base     = {1'b0, ofs_rdata};
	assign pos_sel  = (is_point && !fv_q) ? to_q : from_q;
	assign a_pos    = base + {1'b0, pos_sel};
	assign b_pos    = base + {1'b0, to_q};
	assign over     = is_point ? (a_pos >= MapLimit) : (b_pos > MapLimit);
	assign l_pos    = is_point ? a_pos : (b_pos - GPOS_W'(1));

	// word mask, first and last words trimmed
	assign lo_w     = (addr_s1 == first_q) ? lo_q : '0;
	assign hi_w     = (addr_s1 == last_q) ? hi_q : TopBit;
	assign mask     = ({WORD_BITS{1'b1}} >> (TopBit - hi_w)) & ({WORD_BITS{1'b1}} << lo_w);
	assign word_hit = |(map_rdata & mask);
	assign walk_end = (state_q == ST_WALK) && v_s1 &&
	                  ((addr_s1 == last_q) || (!is_mark && word_hit));
	assign issue    = (state_q == ST_WALK) && issue_q && !walk_end;

	always_comb begin
		if (state_q == ST_CLR) begin
			map_we    = 1'b1;
			map_waddr = clr_cnt_q;
			map_wdata = '0;
		end else begin
			map_we    = (state_q == ST_WALK) && v_s1 && is_mark;
			map_waddr = addr_s1;
			map_wdata = map_rdata | mask;
		end
	end
	assign map_re = issue;

	ibmq_ram #(
		.DEPTH (MAP_WORDS),
		.WIDTH (WORD_BITS)
	) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.re    (map_re),
		.raddr (rd_addr_q),
		.rdata (map_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_cnt_q <= '0;
			issue_q   <= 1'b0;
			v_s1      <= 1'b0;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + MAP_AW'(1);
					if (clr_cnt_q == MAP_AW'(MAP_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						if (req.req_type == REQ_LOAD || err_form) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_OFS;
						end
					end
				end
				ST_OFS: begin
					if (over) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_WALK;
						issue_q <= 1'b1;
					end
				end
				ST_WALK: begin
					// no read is issued in the last cycle, so v_s1 drops there
					v_s1 <= issue;
					if (issue && rd_addr_q == last_q) begin
						issue_q <= 1'b0;
					end
					if (walk_end) begin
						state_q <= ST_DONE;
						issue_q <= 1'b0;
					end
				end
				ST_DONE: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			type_q     <= req.req_type;
			from_q     <= req.from_pos;
			to_q       <= req.to_pos;
			fv_q       <= req.from_valid;
			rsp_q.hit  <= 1'b0;
			rsp_q.status <= err_form ? STAT_FORM : STAT_OK;
		end
		if (state_q == ST_OFS) begin
			first_q   <= a_pos[WORD_W +: MAP_AW];
			last_q    <= l_pos[WORD_W +: MAP_AW];
			lo_q      <= a_pos[WORD_W-1:0];
			hi_q      <= l_pos[WORD_W-1:0];
			rd_addr_q <= a_pos[WORD_W +: MAP_AW];
			if (over) begin
				rsp_q.status <= STAT_RANGE;
			end
		end
		if (issue) begin
			rd_addr_q <= rd_addr_q + MAP_AW'(1);
			addr_s1   <= rd_addr_q;
		end
		if (walk_end) begin
			rsp_q.hit <= !is_mark && word_hit;
		end
	end

	assign res.valid = (state_q == ST_DONE);
	assign res.rsp   = rsp_q;

	a_mark_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		(map_we && state_q == ST_WALK) |-> (addr_s1 >= first_q && addr_s1 <= last_q))
		else $error("map write outside the interval words");

	a_err_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.rsp.status != STAT_OK) |-> !res.rsp.hit)
		else $error("error result carries a hit");

	a_clr_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR && clr_cnt_q == MAP_AW'(MAP_WORDS - 1)) |=> (state_q == ST_IDLE))
		else $error("clearing pass did not finish");

	a_acc_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (state_q == ST_OFS || state_q == ST_DONE))
		else $error("accepted transfer left no work");

	a_mark_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && is_mark) |-> !res.rsp.hit)
		else $error("mark request reported a hit");

endmodule

@@ verif/interval_bitmap_mark_and_query_tb.sv @@
`timescale 1ns / 1ps

module interval_bitmap_mark_and_query_tb;
	import ibmq_pkg::*;

	localparam int unsigned HALF_PERIOD  = 5;
	localparam int unsigned QUIET_LIMIT  = 100000;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned TAIL_CYCLES  = 64;
	localparam int unsigned REPORT_LIMIT = 40;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	ibmq_req_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	ibmq_rsp_t rsp;

	// copy of the block's state, kept in step with accepted requests
	bit [WORD_BITS-1:0] map_words [MAP_WORDS];
	bit [POS_W-1:0]     seq_base [MAX_SEQS];
	bit                 seq_set [MAX_SEQS];
	int unsigned        loaded_seqs [$];
	ibmq_rsp_t          answers_due [$];

	int unsigned fail_count = 0;
	bit          calm = 1'b0;
	bit          hold_rsp = 1'b0;

	interval_bitmap_mark_and_query i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	function automatic ibmq_rsp_t map_apply(input ibmq_req_t r);
		ibmq_rsp_t            ans;
		longint unsigned      lo;
		longint unsigned      hi;
		longint unsigned      g;
		longint unsigned      w;
		longint unsigned      b0;
		longint unsigned      b1;
		bit [WORD_BITS-1:0]   span;
		ans.hit    = 1'b0;
		ans.status = STAT_OK;
		if (r.req_type == REQ_LOAD) begin
			if (r.seq_index >= MAX_SEQS) begin
				ans.status = STAT_RANGE;
			end else begin
				if (!seq_set[r.seq_index])
					loaded_seqs.insert(loaded_seqs.size(), 32'(r.seq_index));
				seq_set[r.seq_index]  = 1'b1;
				seq_base[r.seq_index] = r.offset_value;
			end
		end else if (r.req_type == REQ_POINT) begin
			if (!r.from_valid && !r.to_valid) begin
				ans.status = STAT_FORM;
			end else if (r.seq_index >= MAX_SEQS) begin
				ans.status = STAT_RANGE;
			end else begin
				// from wins when both endpoints are given
				g = longint'(seq_base[r.seq_index]) +
					longint'(r.from_valid ? r.from_pos : r.to_pos);
				if (g >= MAP_POSITIONS)
					ans.status = STAT_RANGE;
				else
					ans.hit = map_words[g / WORD_BITS][g % WORD_BITS];
			end
		end else begin
			if (!r.from_valid || !r.to_valid || r.from_pos >= r.to_pos) begin
				ans.status = STAT_FORM;
			end else if (r.seq_index >= MAX_SEQS) begin
				ans.status = STAT_RANGE;
			end else begin
				lo = longint'(seq_base[r.seq_index]) + longint'(r.from_pos);
				hi = longint'(seq_base[r.seq_index]) + longint'(r.to_pos);
				if (hi > MAP_POSITIONS) begin
					ans.status = STAT_RANGE;
				end else begin
					for (w = lo / WORD_BITS; w <= (hi - 1) / WORD_BITS && !ans.hit; w++) begin
						b0   = (w == lo / WORD_BITS) ? lo % WORD_BITS : 0;
						b1   = (w == (hi - 1) / WORD_BITS) ? (hi - 1) % WORD_BITS : WORD_BITS - 1;
						span = ({WORD_BITS{1'b1}} >> (WORD_BITS - 1 - b1)) &
							({WORD_BITS{1'b1}} << b0);
						if (r.req_type == REQ_MARK)
							map_words[w] |= span;
						else if ((map_words[w] & span) != '0)
							ans.hit = 1'b1;
					end
				end
			end
		end
		return ans;
	endfunction

	function automatic ibmq_req_t mk_req(input logic [1:0] kind, input int unsigned seq,
			input int unsigned from, input bit fv, input int unsigned to, input bit tv,
			input int unsigned off);
		ibmq_req_t r;
		r.req_type     = kind;
		r.seq_index    = SEQ_W'(seq);
		r.from_pos     = POS_W'(from);
		r.from_valid   = fv;
		r.to_pos       = POS_W'(to);
		r.to_valid     = tv;
		r.offset_value = POS_W'(off);
		return r;
	endfunction

	// mostly short intervals in the low part of the map so marks and queries overlap
	function automatic ibmq_req_t random_request();
		ibmq_req_t   r;
		int unsigned roll;
		int unsigned len;
		bit          reads_base;
		roll           = $urandom_range(0, 99);
		len            = ($urandom_range(0, 99) < 5) ? $urandom_range(65, 2000) :
			$urandom_range(1, 64);
		r.seq_index    = SEQ_W'($urandom_range(0, 255));
		r.from_pos     = POS_W'($urandom_range(0, 65535));
		r.to_pos       = POS_W'(r.from_pos + len);
		r.from_valid   = ($urandom_range(0, 99) < 90);
		r.to_valid     = ($urandom_range(0, 99) < 90);
		r.offset_value = POS_W'($urandom());
		if (roll < 10) begin
			r.req_type = REQ_LOAD;
			case ($urandom_range(0, 9))
				0, 1: ;
				2: r.offset_value = POS_W'(MAP_POSITIONS - $urandom_range(0, 4096));
				default: r.offset_value = POS_W'($urandom_range(0, 262143));
			endcase
		end else begin
			r.req_type = (roll < 45) ? REQ_MARK : (roll < 75) ? REQ_RANGE : REQ_POINT;
			if ($urandom_range(0, 9) == 0) begin
				r.from_pos = POS_W'($urandom());
				r.to_pos   = POS_W'(r.from_pos + $urandom_range(0, 64));
			end
			if ($urandom_range(0, 19) == 0)
				{r.from_pos, r.to_pos} = {r.to_pos, r.from_pos};
			reads_base = (r.req_type == REQ_POINT) ? (r.from_valid || r.to_valid) :
				(r.from_valid && r.to_valid && r.from_pos < r.to_pos);
			// never look up an offset that was not loaded
			if (reads_base && !seq_set[r.seq_index])
				r.seq_index = SEQ_W'(loaded_seqs[$urandom_range(0, loaded_seqs.size() - 1)]);
		end
		return r;
	endfunction

	task automatic send_req(input ibmq_req_t r);
		if (!calm && $urandom_range(0, 99) < 32) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		answers_due.insert(answers_due.size(), map_apply(r));
	endtask

	// a full-map walk, other wide walks and one big mark, kept to a handful of requests
	task automatic test_wide_spans();
		send_req(mk_req(REQ_LOAD, 7, 0, 0, 0, 0, 0));
		send_req(mk_req(REQ_RANGE, 7, 0, 1, MAP_POSITIONS, 1, 0));
		send_req(mk_req(REQ_LOAD, 200, 0, 0, 0, 0, 700000));
		send_req(mk_req(REQ_MARK, 200, 0, 1, 300000, 1, 0));
		send_req(mk_req(REQ_RANGE, 7, 0, 1, 700000, 1, 0));
		send_req(mk_req(REQ_RANGE, 7, 0, 1, 700001, 1, 0));
		send_req(mk_req(REQ_POINT, 200, 5, 0, 299999, 1, 0));
		send_req(mk_req(REQ_RANGE, 7, 1000000, 1, MAP_POSITIONS, 1, 0));
	endtask

	task automatic test_edge_cases();
		send_req(mk_req(REQ_LOAD, 0, 0, 0, 0, 0, 0));
		send_req(mk_req(REQ_LOAD, 255, 0, 0, 0, 0, MAP_POSITIONS - WORD_BITS));
		send_req(mk_req(REQ_LOAD, 1, 0, 0, 0, 0, 2097151));
		send_req(mk_req(REQ_MARK, 0, 0, 1, 1, 1, 0));
		send_req(mk_req(REQ_POINT, 0, 0, 1, 5, 1, 0));
		send_req(mk_req(REQ_POINT, 0, 0, 0, 1, 1, 0));
		send_req(mk_req(REQ_POINT, 0, 0, 0, 0, 0, 0));
		send_req(mk_req(REQ_MARK, 0, 10, 0, 20, 1, 0));
		send_req(mk_req(REQ_MARK, 0, 10, 1, 20, 0, 0));
		send_req(mk_req(REQ_RANGE, 0, 20, 1, 20, 1, 0));
		send_req(mk_req(REQ_RANGE, 0, 30, 1, 20, 1, 0));
		// last word of the map, ending exactly on its edge and one past it
		send_req(mk_req(REQ_MARK, 255, 0, 1, 64, 1, 0));
		send_req(mk_req(REQ_MARK, 255, 0, 1, 65, 1, 0));
		send_req(mk_req(REQ_POINT, 0, MAP_POSITIONS - 1, 1, 0, 0, 0));
		send_req(mk_req(REQ_POINT, 0, MAP_POSITIONS, 1, 0, 0, 0));
		send_req(mk_req(REQ_POINT, 1, 7, 0, 0, 1, 0));
		send_req(mk_req(REQ_RANGE, 1, 0, 1, 1, 1, 0));
		// malformed is reported ahead of out of range
		send_req(mk_req(REQ_MARK, 1, 0, 0, 1, 1, 0));
		send_req(mk_req(REQ_MARK, 0, 100, 1, 300, 1, 0));
		send_req(mk_req(REQ_RANGE, 0, 299, 1, 300, 1, 0));
		send_req(mk_req(REQ_RANGE, 0, 300, 1, 400, 1, 0));
		send_req(mk_req(REQ_RANGE, 0, 1, 1, 100, 1, 0));
		send_req(mk_req(REQ_POINT, 0, 2097151, 1, 2097151, 1, 0));
		send_req(mk_req(REQ_LOAD, 128, 0, 0, 0, 0, MAP_POSITIONS));
		send_req(mk_req(REQ_POINT, 128, 0, 1, 0, 0, 0));
	endtask

	// receiver holds off for a long stretch while requests keep coming
	task automatic test_output_backpressure();
		hold_rsp = 1'b1;
		repeat (12) send_req(random_request());
	endtask

	task automatic test_random_mix(input int unsigned count);
		repeat (count) send_req(random_request());
	endtask

	task automatic test_back_to_back(input int unsigned count);
		calm = 1'b1;
		repeat (count) send_req(random_request());
		calm = 1'b0;
	endtask

	initial begin : rsp_side
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rsp = 1'b0;
			end
			rsp_stall <= (!calm && $urandom_range(0, 99) < 32);
		end
	end

	always @(posedge clk) begin : check_rsp
		ibmq_rsp_t due;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (answers_due.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("%0t: no response expected, got hit=%0b status=%0d",
						$time, rsp.hit, rsp.status);
			end else begin
				due = answers_due.pop_front();
				if (rsp.hit !== due.hit || rsp.status !== due.status) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("%0t: expected hit=%0b status=%0d, got hit=%0b status=%0d",
							$time, due.hit, due.status, rsp.hit, rsp.status);
				end
			end
		end
	end

	// counts cycles without any transfer on either side
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		req_valid = 1'b0;
		req       = '0;
		arst_n    = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_wide_spans();
		test_edge_cases();
		test_output_backpressure();
		test_random_mix(900);
		test_back_to_back(450);
		req_valid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
